// ----- rtl/pblu_pkg.sv -----
// shared types and constants for the pump and burner thermostat lockout unit
`default_nettype none
package pblu_pkg;

    // command codes of an input beat
    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_SET_PUMP   = 2'd1;
    localparam logic [1:0] CMD_SET_BURNER = 2'd2;

    // pump modes
    typedef enum logic [1:0] {
        PUMP_OFF   = 2'd0,
        PUMP_ON    = 2'd1,
        PUMP_TEMP  = 2'd2,
        PUMP_FLOAT = 2'd3
    } pump_mode_t;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MASH_TARGET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HLT_TARGET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PUMP_MODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REMOTE_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PUMP_TEMP_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PUMP_FLT_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BURNER_LO    = 3'd6;

    // register reset values
    localparam logic signed [15:0] MASH_TARGET_RST    = 16'sd2400;
    localparam logic signed [15:0] HLT_TARGET_RST     = 16'sd2592;
    localparam logic [15:0]        PUMP_TEMP_LO_RST   = 16'd5000;
    localparam logic [15:0]        PUMP_FLOAT_LO_RST  = 16'd2000;
    localparam logic [15:0]        BURNER_LO_RST      = 16'd5000;

    // half a degree in sixteenths
    localparam logic signed [16:0] HALF_DEGREE = 17'sd8;

    typedef struct packed {
        logic [1:0]         command;
        logic               set_value;
        logic [31:0]        now_ms;
        logic signed [15:0] mash_temp;
        logic signed [15:0] hlt_temp;
        logic               mash_float;
        logic               hlt_float;
    } in_item_t;

    typedef struct packed {
        logic pump_on;
        logic burner_on;
        logic pump_changed;
        logic burner_changed;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] mash_target;
        logic signed [15:0] hlt_target;
        pump_mode_t         pump_mode;
        logic               remote_mode;
        logic [15:0]        pump_temp_lockout_ms;
        logic [15:0]        pump_float_lockout_ms;
        logic [15:0]        burner_lockout_ms;
    } cfg_t;

    typedef struct packed {
        logic        pump_on;
        logic        burner_on;
        logic [31:0] pump_time;
        logic [31:0] burner_time;
    } drive_state_t;

endpackage
`default_nettype wire

// ----- rtl/pblu_decide.sv -----
// decision logic: next pump and burner state and the result beat for one item
`default_nettype none
module pblu_decide
    import pblu_pkg::*;
(
    input  in_item_t     item,
    input  cfg_t         cfg,
    input  drive_state_t cur,
    output drive_state_t nxt,
    output out_item_t    result
);

    logic [31:0]        pump_elapsed;
    logic [31:0]        burner_elapsed;
    logic signed [16:0] mash_thresh;
    logic signed [16:0] hlt_thresh;
    logic               mash_cold;
    logic               hlt_cold;
    logic               pump_want;
    logic [15:0]        pump_lockout;
    logic               pump_chg;
    logic               burner_chg;

    assign pump_elapsed   = item.now_ms - cur.pump_time;
    assign burner_elapsed = item.now_ms - cur.burner_time;

    // 17 bits so a target near the bottom of the range cannot wrap
    assign mash_thresh = $signed({cfg.mash_target[15], cfg.mash_target}) - HALF_DEGREE;
    assign hlt_thresh  = $signed({cfg.hlt_target[15], cfg.hlt_target}) - HALF_DEGREE;
    assign mash_cold   = $signed({item.mash_temp[15], item.mash_temp}) <= mash_thresh;
    assign hlt_cold    = $signed({item.hlt_temp[15], item.hlt_temp}) <= hlt_thresh;

    assign pump_want    = (cfg.pump_mode == PUMP_TEMP) ? mash_cold : !item.mash_float;
    assign pump_lockout = (cfg.pump_mode == PUMP_TEMP) ? cfg.pump_temp_lockout_ms
                                                       : cfg.pump_float_lockout_ms;

    always_comb begin
        nxt        = cur;
        pump_chg   = 1'b0;
        burner_chg = 1'b0;
        case (item.command)
            CMD_SET_PUMP: begin
                nxt.pump_on   = item.set_value;
                nxt.pump_time = item.now_ms;
                pump_chg      = 1'b1;
            end
            CMD_SET_BURNER: begin
                nxt.burner_on   = item.set_value;
                nxt.burner_time = item.now_ms;
                burner_chg      = 1'b1;
            end
            CMD_TICK: begin
                if (!cfg.remote_mode) begin
                    case (cfg.pump_mode)
                        PUMP_OFF: begin
                            pump_chg = cur.pump_on;
                        end
                        PUMP_ON: begin
                            pump_chg = !cur.pump_on;
                        end
                        PUMP_TEMP, PUMP_FLOAT: begin
                            if (pump_want) begin
                                pump_chg = !cur.pump_on
                                           && (pump_elapsed >= {16'd0, pump_lockout});
                            end else begin
                                pump_chg = cur.pump_on;
                            end
                        end
                        default: begin
                            pump_chg = 1'b0;
                        end
                    endcase
                end
                if (!item.hlt_float) begin
                    burner_chg = cur.burner_on;
                end else if (!cfg.remote_mode) begin
                    if (hlt_cold) begin
                        burner_chg = !cur.burner_on
                                     && (burner_elapsed > {16'd0, cfg.burner_lockout_ms});
                    end else begin
                        burner_chg = cur.burner_on;
                    end
                end
                // every automatic change is a toggle of the current drive
                if (pump_chg) begin
                    nxt.pump_on   = !cur.pump_on;
                    nxt.pump_time = item.now_ms;
                end
                if (burner_chg) begin
                    nxt.burner_on   = !cur.burner_on;
                    nxt.burner_time = item.now_ms;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

    assign result.pump_on        = nxt.pump_on;
    assign result.burner_on      = nxt.burner_on;
    assign result.pump_changed   = pump_chg;
    assign result.burner_changed = burner_chg;

endmodule
`default_nettype wire

// ----- rtl/pump_burner_thermostat_lockout_unit.sv -----
// top level of the pump and burner thermostat with restart lockout
// result path: the accepted input beat is held in the input register, and its
//   result is registered in the result register
// throughput: one beat per cycle unless m_ready stalls the result stage, set by a
//   single pass of the decision logic between the input register and the result register
// reset (aresetn low, synchronous): both stages empty, pump and burner off,
//   change times zero, configuration registers back to their defaults
`default_nettype none
module pump_burner_thermostat_lockout_unit
    import pblu_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input beats
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    // result beats
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);

    // configuration registers
    cfg_t         cfg_reg;

    // pump and burner drive state with change time stamps
    drive_state_t state_reg;
    drive_state_t state_next;

    // input stage
    logic         in_valid_reg;
    in_item_t     in_item_reg;

    // result stage
    logic         out_valid_reg;
    out_item_t    out_item_reg;
    out_item_t    out_item_next;

    logic         out_free;
    logic         advance;

    // result register frees when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_ready;
    // the item in the input stage is decided and moves on
    assign advance  = in_valid_reg && out_free;
    // input stage takes a beat when empty or draining into the result stage
    assign s_ready  = !in_valid_reg || out_free;

    // configuration writes, to be issued by the user only while the unit is idle; the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mash_target           <= MASH_TARGET_RST;
            cfg_reg.hlt_target            <= HLT_TARGET_RST;
            cfg_reg.pump_mode             <= PUMP_OFF;
            cfg_reg.remote_mode           <= 1'b0;
            cfg_reg.pump_temp_lockout_ms  <= PUMP_TEMP_LO_RST;
            cfg_reg.pump_float_lockout_ms <= PUMP_FLOAT_LO_RST;
            cfg_reg.burner_lockout_ms     <= BURNER_LO_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MASH_TARGET:  cfg_reg.mash_target           <= $signed(cfg_wdata);
                REG_HLT_TARGET:   cfg_reg.hlt_target            <= $signed(cfg_wdata);
                REG_PUMP_MODE:    cfg_reg.pump_mode             <= pump_mode_t'(cfg_wdata[1:0]);
                REG_REMOTE_MODE:  cfg_reg.remote_mode           <= cfg_wdata[0];
                REG_PUMP_TEMP_LO: cfg_reg.pump_temp_lockout_ms  <= cfg_wdata;
                REG_PUMP_FLT_LO:  cfg_reg.pump_float_lockout_ms <= cfg_wdata;
                REG_BURNER_LO:    cfg_reg.burner_lockout_ms     <= cfg_wdata;
                default: begin
                    // index past the register list: write dropped
                end
            endcase
        end
    end

    // input stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    // thermostat and lockout decision for the item in the input stage
    pblu_decide u_decide (
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (out_item_next)
    );

    // drive state moves only when the item leaves the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule
`default_nettype wire

// ----- rtl/pblu_checker.sv -----
// port level checks for the thermostat lockout unit and their bind
`default_nettype none
module pblu_checker
    import pblu_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire out_item_t             m_data
);

    // drive levels carried by the last delivered result beat
    logic last_pump_reg;
    logic last_burner_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pump_reg   <= 1'b0;
            last_burner_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            last_pump_reg   <= m_data.pump_on;
            last_burner_reg <= m_data.burner_on;
        end
    end

    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    // input is only held off by a stalled full result stage
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without result back-pressure");

    // pump level only moves with a reported change
    a_pump_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.pump_changed |-> m_data.pump_on == last_pump_reg)
        else $error("pump level moved without a change");

    // burner level only moves with a reported change
    a_burner_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.burner_changed |-> m_data.burner_on == last_burner_reg)
        else $error("burner level moved without a change");

endmodule

bind pump_burner_thermostat_lockout_unit pblu_checker u_pblu_checker (.*);
`default_nettype wire

// ----- sim/tb_pump_burner_thermostat_lockout_unit.sv -----
// self-checking testbench for the pump and burner thermostat lockout unit
`timescale 1ns / 100ps
module tb_pump_burner_thermostat_lockout_unit;
    import pblu_pkg::*;

    // the one command code that the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // register index past the last register, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    localparam int unsigned RANDOM_PHASES   = 12;
    localparam int unsigned BEATS_PER_PHASE = 160;

    // clock, reset and every block input start at a known value
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    // beats waiting to be driven, and drive results still owed by the block
    in_item_t  pending_beats[$];
    out_item_t expected_drive[$];

    int unsigned beats_queued = 0;
    int unsigned results_seen = 0;
    int unsigned error_count  = 0;

    // predictor copy of the settings and of the pump and burner drive
    cfg_t regs = '{MASH_TARGET_RST, HLT_TARGET_RST, PUMP_OFF, 1'b0,
                   PUMP_TEMP_LO_RST, PUMP_FLOAT_LO_RST, BURNER_LO_RST};
    drive_state_t plant = '0;

    // handshake seen at the last rising edge, used by the driver at the falling edge
    logic in_fire = 1'b0;

    // idling state of both sides
    int unsigned send_gap   = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_left = 0;

    pump_burner_thermostat_lockout_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 12 ns period
    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // predictor: one drive result for every accepted input beat
    // ------------------------------------------------------------------
    function automatic out_item_t thermostat_step(input in_item_t b);
        out_item_t   r;
        logic [31:0] pump_elapsed;
        logic [31:0] burner_elapsed;
        logic [15:0] restart_gap;
        logic        pump_wanted;
        r = '0;
        case (b.command)
            CMD_SET_PUMP: begin
                // manual set always stamps, even when the value is unchanged
                plant.pump_on   = b.set_value;
                plant.pump_time = b.now_ms;
                r.pump_changed  = 1'b1;
            end
            CMD_SET_BURNER: begin
                plant.burner_on   = b.set_value;
                plant.burner_time = b.now_ms;
                r.burner_changed  = 1'b1;
            end
            CMD_TICK: begin
                // elapsed times wrap modulo 2^32
                pump_elapsed = b.now_ms - plant.pump_time;
                if (!regs.remote_mode) begin
                    // off and on modes behave as a thermostat with no lockout
                    case (regs.pump_mode)
                        PUMP_OFF:  pump_wanted = 1'b0;
                        PUMP_ON:   pump_wanted = 1'b1;
                        PUMP_TEMP: pump_wanted = int'($signed(b.mash_temp)) <=
                                       int'($signed(regs.mash_target)) - int'(HALF_DEGREE);
                        default:   pump_wanted = !b.mash_float;
                    endcase
                    case (regs.pump_mode)
                        PUMP_TEMP:  restart_gap = regs.pump_temp_lockout_ms;
                        PUMP_FLOAT: restart_gap = regs.pump_float_lockout_ms;
                        default:    restart_gap = '0;
                    endcase
                    if (pump_wanted) begin
                        if (!plant.pump_on && pump_elapsed >= 32'(restart_gap)) begin
                            plant.pump_on   = 1'b1;
                            plant.pump_time = b.now_ms;
                            r.pump_changed  = 1'b1;
                        end
                    end else if (plant.pump_on) begin
                        plant.pump_on   = 1'b0;
                        plant.pump_time = b.now_ms;
                        r.pump_changed  = 1'b1;
                    end
                end
                burner_elapsed = b.now_ms - plant.burner_time;
                if (!b.hlt_float) begin
                    // low tank level stops the burner even under remote control
                    if (plant.burner_on) begin
                        plant.burner_on   = 1'b0;
                        plant.burner_time = b.now_ms;
                        r.burner_changed  = 1'b1;
                    end
                end else if (!regs.remote_mode) begin
                    if (int'($signed(b.hlt_temp)) <=
                        int'($signed(regs.hlt_target)) - int'(HALF_DEGREE)) begin
                        // burner lockout is strictly greater than
                        if (!plant.burner_on &&
                            burner_elapsed > 32'(regs.burner_lockout_ms)) begin
                            plant.burner_on   = 1'b1;
                            plant.burner_time = b.now_ms;
                            r.burner_changed  = 1'b1;
                        end
                    end else if (plant.burner_on) begin
                        plant.burner_on   = 1'b0;
                        plant.burner_time = b.now_ms;
                        r.burner_changed  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.pump_on   = plant.pump_on;
        r.burner_on = plant.burner_on;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // reporting and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_result(input out_item_t got, input out_item_t want);
        if (got.pump_on !== want.pump_on)
            report_mismatch($sformatf("result %0d pump_on %b, predicted %b",
                                      results_seen, got.pump_on, want.pump_on));
        if (got.burner_on !== want.burner_on)
            report_mismatch($sformatf("result %0d burner_on %b, predicted %b",
                                      results_seen, got.burner_on, want.burner_on));
        if (got.pump_changed !== want.pump_changed)
            report_mismatch($sformatf("result %0d pump_changed %b, predicted %b",
                                      results_seen, got.pump_changed, want.pump_changed));
        if (got.burner_changed !== want.burner_changed)
            report_mismatch($sformatf("result %0d burner_changed %b, predicted %b",
                                      results_seen, got.burner_changed, want.burner_changed));
    endtask

    // ------------------------------------------------------------------
    // idling: mostly short gaps, a few long ones, and quiet stretches
    // ------------------------------------------------------------------
    function automatic int unsigned idle_len();
        int unsigned r;
        if (quiet_left != 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // now and then both sides run flat out for a while
    always @(posedge aclk) begin
        if (quiet_left != 0) begin
            quiet_left <= quiet_left - 1;
        end else if ($urandom_range(0, 399) == 0) begin
            quiet_left <= $urandom_range(40, 200);
        end
    end

    // ------------------------------------------------------------------
    // driver: input beats from the pending queue, changed at the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_fire) begin
            // beat offered but not yet taken, hold it as it is
        end else if (send_gap != 0) begin
            s_valid  <= 1'b0;
            send_gap = send_gap - 1;
        end else if (pending_beats.size() != 0) begin
            s_data   <= pending_beats.pop_front();
            s_valid  <= 1'b1;
            send_gap = idle_len();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left = idle_len();
        end
    end

    // ------------------------------------------------------------------
    // monitor: sample both channels at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_drive.size() == 0)
                    report_mismatch($sformatf("result %0d with nothing predicted",
                                              results_seen));
                else
                    check_result(m_data, expected_drive.pop_front());
            end
            // the block's latency keeps a fresh beat from meeting its own result
            if (s_valid && s_ready) expected_drive.push_back(thermostat_step(s_data));
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_beat(input logic [1:0] cmd, input logic setv,
                              input logic [31:0] now, input logic [15:0] mash,
                              input logic [15:0] hlt, input logic mfloat,
                              input logic hfloat);
        in_item_t b;
        b.command    = cmd;
        b.set_value  = setv;
        b.now_ms     = now;
        b.mash_temp  = mash;
        b.hlt_temp   = hlt;
        b.mash_float = mfloat;
        b.hlt_float  = hfloat;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // caller stands at a falling edge; the write lands at the next rising edge
    // and cfg_we is dropped by the caller once the group of writes is done
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_MASH_TARGET:  regs.mash_target           = val;
            REG_HLT_TARGET:   regs.hlt_target            = val;
            REG_PUMP_MODE:    regs.pump_mode             = pump_mode_t'(val[1:0]);
            REG_REMOTE_MODE:  regs.remote_mode           = val[0];
            REG_PUMP_TEMP_LO: regs.pump_temp_lockout_ms  = val;
            REG_PUMP_FLT_LO:  regs.pump_float_lockout_ms = val;
            REG_BURNER_LO:    regs.burner_lockout_ms     = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // block drained: every beat answered, plus the pipeline depth and a margin
    task automatic wait_idle();
        while (results_seen < beats_queued) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // temperatures clustered round the switching threshold, some anywhere
    function automatic logic [15:0] temp_near(input logic signed [15:0] target);
        int t;
        if ($urandom_range(0, 6) == 0) return 16'($urandom);
        t = int'($signed(target)) - int'(HALF_DEGREE) + int'($urandom_range(0, 8)) - 4;
        return 16'(t);
    endfunction

    // first phases take the target extremes, later ones realistic or arbitrary
    function automatic logic [15:0] pick_target(input int unsigned ph);
        if (ph == 0) return 16'h8000;
        if (ph == 1) return 16'h7fff;
        if (ph % 3 == 0) return 16'($urandom);
        return 16'($urandom_range(800, 3200));
    endfunction

    // lockouts: zero, full scale, arbitrary, or short enough to be reached often
    function automatic logic [15:0] pick_lockout(input int unsigned ph);
        if (ph == 2) return 16'h0000;
        if (ph == 3) return 16'hffff;
        if (ph % 4 == 1) return 16'($urandom);
        return 16'($urandom_range(0, 3000));
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned  ph;
        int unsigned  n;
        int unsigned  r;
        logic [31:0]  clock_ms;
        logic [1:0]   cmd;
        logic [15:0]  v;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // defaults: pump mode off, burner lockout 5000, tank threshold 2584
        queue_beat(CMD_TICK, 1'b0, 32'd0, 16'h0000, 16'h8000, 1'b1, 1'b1);
        // elapsed equal to the burner lockout does not light it
        queue_beat(CMD_TICK, 1'b0, 32'd5000, 16'h0000, 16'd2584, 1'b1, 1'b1);
        queue_beat(CMD_TICK, 1'b0, 32'd5001, 16'h0000, 16'd2584, 1'b1, 1'b1);
        // one sixteenth above the threshold stops it
        queue_beat(CMD_TICK, 1'b0, 32'd5002, 16'h0000, 16'd2585, 1'b1, 1'b1);
        queue_beat(CMD_TICK, 1'b0, 32'd20000, 16'h0000, 16'h8000, 1'b1, 1'b0);
        queue_beat(CMD_TICK, 1'b0, 32'd20001, 16'h0000, 16'h8000, 1'b1, 1'b1);
        // low tank float stops a running burner
        queue_beat(CMD_TICK, 1'b0, 32'd20002, 16'h0000, 16'h8000, 1'b1, 1'b0);
        queue_beat(CMD_SET_PUMP, 1'b1, 32'd30000, 16'h7fff, 16'h7fff, 1'b0, 1'b0);
        // mode off stops a manually started pump on the next tick
        queue_beat(CMD_TICK, 1'b0, 32'd30001, 16'h7fff, 16'h7fff, 1'b0, 1'b1);
        // manual sets with unchanged value still count as a change
        queue_beat(CMD_SET_PUMP, 1'b0, 32'd30002, 16'h7fff, 16'h7fff, 1'b1, 1'b1);
        queue_beat(CMD_SET_BURNER, 1'b1, 32'd30003, 16'h8000, 16'h8000, 1'b0, 1'b0);
        queue_beat(CMD_SET_BURNER, 1'b1, 32'd30004, 16'h8000, 16'h8000, 1'b1, 1'b1);
        queue_beat(CMD_SET_BURNER, 1'b0, 32'd30005, 16'h8000, 16'h8000, 1'b0, 1'b1);
        // unused command leaves everything alone
        queue_beat(CMD_UNUSED, 1'b1, 32'hffff_ffff, 16'h7fff, 16'h8000, 1'b1, 1'b1);

        // remote control: automatic decisions held, float stop still acts
        wait_idle();
        write_reg(REG_PUMP_MODE, 16'(PUMP_ON));
        write_reg(REG_REMOTE_MODE, 16'd1);
        cfg_we <= 1'b0;
        queue_beat(CMD_SET_BURNER, 1'b1, 32'd40000, 16'h0000, 16'h7fff, 1'b1, 1'b1);
        queue_beat(CMD_TICK, 1'b0, 32'd40001, 16'h0000, 16'h7fff, 1'b1, 1'b1);
        queue_beat(CMD_TICK, 1'b0, 32'd40002, 16'h0000, 16'h7fff, 1'b1, 1'b0);

        wait_idle();
        write_reg(REG_REMOTE_MODE, 16'd0);
        cfg_we <= 1'b0;
        queue_beat(CMD_TICK, 1'b0, 32'd40003, 16'h0000, 16'h7fff, 1'b1, 1'b1);

        // temperature mode at the top target and full-scale lockouts,
        // with the pump change stamp just below the wrap point
        wait_idle();
        write_reg(REG_MASH_TARGET, 16'h7fff);
        write_reg(REG_HLT_TARGET, 16'h8000);
        write_reg(REG_PUMP_MODE, 16'(PUMP_TEMP));
        write_reg(REG_PUMP_TEMP_LO, 16'hffff);
        write_reg(REG_BURNER_LO, 16'hffff);
        cfg_we <= 1'b0;
        queue_beat(CMD_SET_PUMP, 1'b0, 32'hffff_fff0, 16'h7ff7, 16'h8000, 1'b1, 1'b1);
        // wrapped elapsed one short of the lockout, then equal to it
        queue_beat(CMD_TICK, 1'b0, 32'h0000_ffee, 16'h7ff7, 16'h8000, 1'b1, 1'b1);
        queue_beat(CMD_TICK, 1'b0, 32'h0000_ffef, 16'h7ff7, 16'h8000, 1'b1, 1'b1);
        queue_beat(CMD_TICK, 1'b0, 32'h0001_0000, 16'h7ff8, 16'h8000, 1'b1, 1'b1);

        // bottom mash target puts the threshold under every temperature,
        // zero lockouts, and a write to a register that does not exist
        wait_idle();
        write_reg(REG_MASH_TARGET, 16'h8000);
        write_reg(REG_HLT_TARGET, 16'h7fff);
        write_reg(REG_PUMP_TEMP_LO, 16'h0000);
        write_reg(REG_PUMP_FLT_LO, 16'h0000);
        write_reg(REG_BURNER_LO, 16'h0000);
        write_reg(REG_NONE, 16'hffff);
        cfg_we <= 1'b0;
        queue_beat(CMD_TICK, 1'b0, 32'd100, 16'h8000, 16'h7ff7, 1'b1, 1'b1);

        wait_idle();
        write_reg(REG_PUMP_MODE, 16'(PUMP_FLOAT));
        cfg_we <= 1'b0;
        queue_beat(CMD_TICK, 1'b0, 32'd200, 16'h0000, 16'h7fff, 1'b0, 1'b1);
        queue_beat(CMD_TICK, 1'b0, 32'd200, 16'h0000, 16'h7fff, 1'b1, 1'b1);
        // zero lockout lets it restart with no time gone at all
        queue_beat(CMD_TICK, 1'b0, 32'd200, 16'h0000, 16'h7fff, 1'b0, 1'b1);

        // random phases: fresh settings each time, every pump mode in turn
        clock_ms = 32'd300;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            write_reg(REG_MASH_TARGET, pick_target(ph));
            write_reg(REG_HLT_TARGET, pick_target(ph + 7));
            v = 16'($urandom);
            v[1:0] = 2'(ph);
            write_reg(REG_PUMP_MODE, v);
            v = 16'($urandom);
            v[0] = (ph % 5 == 4);
            write_reg(REG_REMOTE_MODE, v);
            write_reg(REG_PUMP_TEMP_LO, pick_lockout(ph));
            write_reg(REG_PUMP_FLT_LO, pick_lockout(ph + 4));
            write_reg(REG_BURNER_LO, pick_lockout(ph));
            cfg_we <= 1'b0;

            for (n = 0; n < BEATS_PER_PHASE; n++) begin
                // time mostly creeps, sometimes leaps past the lockouts or anywhere
                r = $urandom_range(0, 99);
                if (r < 60)      clock_ms = clock_ms + $urandom_range(0, 400);
                else if (r < 85) clock_ms = clock_ms + $urandom_range(400, 6000);
                else if (r < 96) clock_ms = clock_ms + $urandom_range(0, 70000);
                else             clock_ms = $urandom;
                r = $urandom_range(0, 99);
                if (r < 80)      cmd = CMD_TICK;
                else if (r < 89) cmd = CMD_SET_PUMP;
                else if (r < 97) cmd = CMD_SET_BURNER;
                else             cmd = CMD_UNUSED;
                queue_beat(cmd, 1'($urandom), clock_ms,
                           temp_near(regs.mash_target), temp_near(regs.hlt_target),
                           $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
            end
        end

        // drain, then give the pipeline time to show any stray beat
        wait_idle();
        repeat (8) @(negedge aclk);
        if (expected_drive.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      expected_drive.size()));
        if (error_count == 0) begin
            $display("tb_pump_burner_thermostat_lockout_unit: done, clean");
        end else begin
            $display("tb_pump_burner_thermostat_lockout_unit: done, errors");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #(20_000_000);
        $display("tb_pump_burner_thermostat_lockout_unit: done, errors");
        $finish;
    end

endmodule
